// File: rtl/core/dotted_path_index_parser_defines.svh
// Assertion macros shared by the dotted path index parser RTL.
`ifndef DOTTED_PATH_INDEX_PARSER_DEFINES_SVH
`define DOTTED_PATH_INDEX_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define DPIP_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("dotted path index parser assertion failed");
`define DPIP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("dotted path index parser assertion failed");
`else
`define DPIP_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define DPIP_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// File: rtl/core/dpip_pkg.sv
// Package with request types, token state and character codes for the path parser.
package dpip_pkg;

    localparam int DefMaxDepth = 3;
    localparam int DefMaxLen   = 255;

    localparam logic [7:0] CharMinus = 8'h2d;
    localparam logic [7:0] CharDot   = 8'h2e;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharPct   = 8'h25;
    localparam logic [7:0] CharLowD  = 8'h64;
    localparam logic [7:0] CharNul   = 8'h00;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_req;

    typedef struct packed {
        logic [1:0]         depth;
        logic signed [31:0] index0;
        logic signed [31:0] index1;
        logic signed [31:0] index2;
        logic               overflow;
    } t_out_req;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  len;
        logic        allnum;
        logic        neg;
        logic        stopped;
        logic        pct;
    } t_token;

    typedef struct packed {
        logic        push;
        logic [31:0] value;
    } t_push;

    localparam t_token TokenClear = '{
        value:   32'd0,
        len:     2'd0,
        allnum:  1'b1,
        neg:     1'b0,
        stopped: 1'b0,
        pct:     1'b0
    };

endpackage

// File: rtl/core/dpip_token.sv
// Token update for one path character and the value a finished token yields.
module dpip_token (
    input  dpip_pkg::t_token i_tok,
    input  logic [7:0]       i_ch,
    input  logic             i_take,
    input  logic             i_last,
    output dpip_pkg::t_token o_tok_next,
    output dpip_pkg::t_push  o_push
);

    logic             dot;
    logic             digit;
    logic             take_char;
    logic             finish;
    dpip_pkg::t_token tok_a;

    assign dot       = (i_ch == dpip_pkg::CharDot);
    assign digit     = (i_ch >= dpip_pkg::CharZero) && (i_ch <= dpip_pkg::CharNine);
    assign take_char = i_take && !dot;
    assign finish    = (i_take && dot) || i_last;

    always_comb begin
        tok_a = i_tok;
        if (take_char) begin
            if (!digit && (i_ch != dpip_pkg::CharMinus)) begin
                tok_a.allnum = 1'b0;
            end
            if (!i_tok.stopped) begin
                if ((i_tok.len == 2'd0) && (i_ch == dpip_pkg::CharMinus)) begin
                    tok_a.neg = 1'b1;
                end else if (digit) begin
                    tok_a.value = {i_tok.value[28:0], 3'b000} + {i_tok.value[30:0], 1'b0}
                                + {28'd0, i_ch[3:0]};
                end else begin
                    tok_a.stopped = 1'b1;
                end
            end
            if (i_tok.len == 2'd0) begin
                tok_a.pct = (i_ch == dpip_pkg::CharPct);
            end else if (i_tok.len == 2'd1) begin
                tok_a.pct = i_tok.pct && (i_ch == dpip_pkg::CharLowD);
            end
            if (i_tok.len != 2'd2) begin
                tok_a.len = i_tok.len + 2'd1;
            end
        end
    end

    always_comb begin
        o_push = '{push: 1'b0, value: 32'd0};
        if (finish && (tok_a.len != 2'd0)) begin
            if (tok_a.allnum) begin
                o_push.push  = 1'b1;
                o_push.value = tok_a.neg ? (32'd0 - tok_a.value) : tok_a.value;
            end else if (tok_a.pct && (tok_a.len == 2'd2)) begin
                o_push.push = 1'b1;
            end
        end
    end

    assign o_tok_next = finish ? dpip_pkg::TokenClear : tok_a;

endmodule

// File: rtl/core/dotted_path_index_parser.sv
// Top level of the dotted path index parser: input register, path state and result register.
//
//   Channel   Handshake                  Payload
//   in        i_in_valid / o_in_ready    i_in_req  (ch, last)
//   out       o_out_valid / i_out_ready  o_out_req (depth, index0..2, overflow)
//
// Each request passes through the input register; one byte enters per cycle unless a final byte is stalled.
// A request with last set is registered in the input register, and its result then in the output register.
// The path state is cleared by reset and again after every result.
// A final byte waits in the input register while the output register is still full.
`include "dotted_path_index_parser_defines.svh"

module dotted_path_index_parser #(
    parameter int MAX_DEPTH = dpip_pkg::DefMaxDepth,
    parameter int MAX_LEN   = dpip_pkg::DefMaxLen
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dpip_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dpip_pkg::t_out_req o_out_req
);

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int BW = $clog2(MAX_LEN + 1);

    logic               r_in_valid;
    dpip_pkg::t_in_req  r_in;
    logic               r_out_valid;
    dpip_pkg::t_out_req r_out;
    dpip_pkg::t_out_req n_out;

    logic [CW-1:0]      r_slot_count;
    logic [CW-1:0]      n_slot_count;
    logic [31:0]        r_slot [MAX_DEPTH];
    logic [31:0]        n_slot [MAX_DEPTH];
    dpip_pkg::t_token   r_tok;
    dpip_pkg::t_token   n_tok;
    logic [BW-1:0]      r_byte_count;
    logic               r_ended;
    logic               r_ovf;
    logic               n_ovf;

    logic               advance;
    logic               consume;
    logic               take;
    logic               push_ok;
    dpip_pkg::t_push    push;
    logic [31:0]        idx [3];

    assign advance    = r_in_valid && (!r_in.last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign consume    = !r_ended && (r_byte_count < BW'(MAX_LEN));
    assign take       = consume && (r_in.ch != dpip_pkg::CharNul);

    dpip_token u_token (
        .i_tok      (r_tok),
        .i_ch       (r_in.ch),
        .i_take     (take),
        .i_last     (r_in.last),
        .o_tok_next (n_tok),
        .o_push     (push)
    );

    assign push_ok = push.push && (r_slot_count < CW'(MAX_DEPTH));

    always_comb begin
        n_slot_count = r_slot_count;
        n_ovf        = r_ovf;
        if (push.push) begin
            if (push_ok) begin
                n_slot_count = r_slot_count + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        for (int k = 0; k < MAX_DEPTH; k++) begin
            n_slot[k] = r_slot[k];
            if (push_ok && (r_slot_count == CW'(k))) begin
                n_slot[k] = push.value;
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_idx
        if (k < MAX_DEPTH) begin : g_live
            assign idx[k] = (n_slot_count > CW'(k)) ? n_slot[k] : 32'd0;
        end else begin : g_zero
            assign idx[k] = 32'd0;
        end
    end

    always_comb begin
        n_out.depth    = 2'(n_slot_count);
        n_out.index0   = idx[0];
        n_out.index1   = idx[1];
        n_out.index2   = idx[2];
        n_out.overflow = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_slot_count <= '0;
            r_tok        <= dpip_pkg::TokenClear;
            r_byte_count <= '0;
            r_ended      <= 1'b0;
            r_ovf        <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && r_in.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (r_in.last) begin
                    r_slot_count <= '0;
                    r_tok        <= dpip_pkg::TokenClear;
                    r_byte_count <= '0;
                    r_ended      <= 1'b0;
                    r_ovf        <= 1'b0;
                end else begin
                    r_slot_count <= n_slot_count;
                    r_tok        <= n_tok;
                    r_ovf        <= n_ovf;
                    if (take) begin
                        r_byte_count <= r_byte_count + BW'(1);
                    end
                    if (consume && !take) begin
                        r_ended <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_req;
        end
        if (advance && r_in.last) begin
            r_out <= n_out;
        end
        if (advance) begin
            for (int k = 0; k < MAX_DEPTH; k++) begin
                r_slot[k] <= n_slot[k];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    `DPIP_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_slot_count <= CW'(MAX_DEPTH))
    `DPIP_ASSERT_IMPLY(a_ovf_full, i_clk, i_rst_n, r_ovf, r_slot_count == CW'(MAX_DEPTH))
    `DPIP_ASSERT_NEXT(a_clear_after_result, i_clk, i_rst_n, advance && r_in.last, (r_slot_count == '0) && !r_ovf && !r_ended && (r_byte_count == '0))
    `DPIP_ASSERT_IMPLY(a_stall_final, i_clk, i_rst_n, r_in_valid && r_in.last && r_out_valid && !i_out_ready, !o_in_ready)

endmodule

// File: dv/dpip_checker.sv
// Checker for the dotted path index parser: predicts each result from accepted requests and compares.
`timescale 1ns / 100ps

module dpip_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  dpip_pkg::t_in_req  i_in_req,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  dpip_pkg::t_out_req i_out_req,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int MaxDepth = dpip_pkg::DefMaxDepth;
    localparam int MaxLen   = dpip_pkg::DefMaxLen;

    dpip_pkg::t_out_req result_q[$];

    int unsigned vals_kept;
    logic [31:0] vals[3];
    logic [31:0] tok_acc;
    int unsigned tok_len;
    bit          tok_num;
    bit          tok_minus;
    bit          tok_halt;
    bit          tok_pct;
    int unsigned path_bytes;
    bit          path_done;
    bit          too_many;

    function void clear_token();
        tok_acc   = 32'd0;
        tok_len   = 0;
        tok_num   = 1'b1;
        tok_minus = 1'b0;
        tok_halt  = 1'b0;
        tok_pct   = 1'b0;
    endfunction

    function void clear_path();
        vals_kept = 0;
        for (int k = 0; k < 3; k++) begin
            vals[k] = 32'd0;
        end
        clear_token();
        path_bytes = 0;
        path_done  = 1'b0;
        too_many   = 1'b0;
    endfunction

    function void keep_value(logic [31:0] v);
        if (vals_kept < MaxDepth) begin
            vals[vals_kept] = v;
            vals_kept++;
        end else begin
            too_many = 1'b1;
        end
    endfunction

    function void close_token();
        if (tok_len > 0) begin
            if (tok_num) begin
                keep_value(tok_minus ? (32'd0 - tok_acc) : tok_acc);
            end else if (tok_pct && tok_len >= 2) begin
                keep_value(32'd0);
            end
        end
        clear_token();
    endfunction

    function void add_char(logic [7:0] c);
        bit is_digit;
        is_digit = (c >= dpip_pkg::CharZero) && (c <= dpip_pkg::CharNine);
        if (!is_digit && c != dpip_pkg::CharMinus) begin
            tok_num = 1'b0;
        end
        if (!tok_halt) begin
            if (tok_len == 0 && c == dpip_pkg::CharMinus) begin
                tok_minus = 1'b1;
            end else if (is_digit) begin
                tok_acc = tok_acc * 32'd10 + 32'(c - dpip_pkg::CharZero);
            end else begin
                tok_halt = 1'b1;
            end
        end
        if (tok_len == 0) begin
            tok_pct = (c == dpip_pkg::CharPct);
        end else if (tok_len == 1) begin
            tok_pct = tok_pct && (c == dpip_pkg::CharLowD);
        end
        if (tok_len < 2) begin
            tok_len++;
        end
    endfunction

    // One accepted request: update the path state and queue a result on the final byte.
    function void path_step(dpip_pkg::t_in_req r);
        dpip_pkg::t_out_req res;
        logic [31:0]        v[3];
        if (!path_done && path_bytes < MaxLen) begin
            if (r.ch == dpip_pkg::CharNul) begin
                path_done = 1'b1;
            end else begin
                path_bytes++;
                if (r.ch == dpip_pkg::CharDot) begin
                    close_token();
                end else begin
                    add_char(r.ch);
                end
            end
        end
        if (r.last) begin
            close_token();
            for (int k = 0; k < 3; k++) begin
                v[k] = (k < MaxDepth && k < vals_kept) ? vals[k] : 32'd0;
            end
            res.depth    = vals_kept[1:0];
            res.index0   = v[0];
            res.index1   = v[1];
            res.index2   = v[2];
            res.overflow = too_many;
            result_q.push_back(res);
            clear_path();
        end
    endfunction

    function int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        dpip_pkg::t_out_req want;
        if (!i_rst_n) begin
            clear_path();
            result_q.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result expected none, actual %0h", $time, i_out_req);
                    o_errors++;
                end else begin
                    want = result_q.pop_front();
                    o_errors += field_diff("depth", 32'(want.depth), 32'(i_out_req.depth));
                    o_errors += field_diff("index0", want.index0, i_out_req.index0);
                    o_errors += field_diff("index1", want.index1, i_out_req.index1);
                    o_errors += field_diff("index2", want.index2, i_out_req.index2);
                    o_errors += field_diff("overflow", 32'(want.overflow),
                                           32'(i_out_req.overflow));
                end
            end
            if (i_in_valid && i_in_ready) begin
                path_step(i_in_req);
            end
        end
        o_pending = result_q.size();
    end

endmodule

// File: dv/tb.sv
// Testbench top for the dotted path index parser: clock, reset, path stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb;

    typedef logic [7:0] t_byte;

    localparam int IdleLimit = 4000;
    localparam int HoldCycles = 300;
    localparam int RandomItems = 850;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    dpip_pkg::t_in_req  in_req;
    logic               out_valid;
    logic               out_ready;
    dpip_pkg::t_out_req out_req;

    int       errors;
    int       pending;
    t_byte    path_buf[$];
    int       live_items;
    int       burst_left;
    bit       hold_req;
    bit       hold_done;
    int       idle_cycles;
    int       rx_mode;
    int       rx_left;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dotted_path_index_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req)
    );

    dpip_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_req    (in_req),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_req   (out_req),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    function void put(t_byte b);
        path_buf.push_back(b);
    endfunction

    function void put_digits(int n);
        repeat (n) put(dpip_pkg::CharZero + t_byte'($urandom_range(0, 9)));
    endfunction

    function void add_token();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                if ($urandom_range(0, 2) == 0) put(dpip_pkg::CharMinus);
                put_digits(($urandom_range(0, 9) == 0) ? $urandom_range(9, 14)
                                                       : $urandom_range(1, 4));
            end
            4: begin
                case ($urandom_range(0, 2))
                    0: put(dpip_pkg::CharMinus);
                    1: begin
                        put(dpip_pkg::CharMinus);
                        put(dpip_pkg::CharMinus);
                        put_digits($urandom_range(1, 3));
                    end
                    default: begin
                        put_digits($urandom_range(1, 3));
                        put(dpip_pkg::CharMinus);
                        put_digits($urandom_range(1, 3));
                    end
                endcase
            end
            5: begin
                put(dpip_pkg::CharPct);
                if ($urandom_range(0, 3) != 0) begin
                    put(dpip_pkg::CharLowD);
                end else begin
                    put(t_byte'($urandom_range(1, 255)));
                end
                repeat ($urandom_range(0, 3)) put(t_byte'($urandom_range(32, 126)));
            end
            6: repeat ($urandom_range(1, 4)) put(t_byte'($urandom_range(1, 255)));
            7: ;
            8: begin
                put_digits($urandom_range(1, 3));
                put(t_byte'($urandom_range(8'h3a, 8'h7e)));
                put_digits($urandom_range(1, 2));
            end
            default: put(t_byte'($urandom_range(0, 255)));
        endcase
    endfunction

    function void make_path();
        int ntok;
        path_buf.delete();
        if ($urandom_range(0, 59) == 0) begin
            repeat ($urandom_range(dpip_pkg::DefMaxLen + 5, dpip_pkg::DefMaxLen + 45)) begin
                if ($urandom_range(0, 7) == 0) begin
                    put(dpip_pkg::CharDot);
                end else begin
                    put_digits(1);
                end
            end
        end else begin
            ntok = $urandom_range(0, 5);
            if ($urandom_range(0, 5) == 0) put(dpip_pkg::CharDot);
            for (int t = 0; t < ntok; t++) begin
                if (t > 0) put(dpip_pkg::CharDot);
                add_token();
            end
            if ($urandom_range(0, 9) == 0) begin
                put(dpip_pkg::CharNul);
                repeat ($urandom_range(0, 4)) put(t_byte'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 7) == 0) put(dpip_pkg::CharDot);
            if (path_buf.size() == 0) begin
                case ($urandom_range(0, 2))
                    0: put(dpip_pkg::CharDot);
                    1: put(dpip_pkg::CharNul);
                    default: put_digits(1);
                endcase
            end
        end
    endfunction

    task send_byte(dpip_pkg::t_in_req r);
        in_req   <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            if ($urandom_range(0, 4) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    task send_path();
        dpip_pkg::t_in_req r;
        int                live;
        bit                ended;
        live  = 0;
        ended = 1'b0;
        for (int i = 0; i < path_buf.size(); i++) begin
            r.ch   = path_buf[i];
            r.last = (i == path_buf.size() - 1);
            if (!ended && live < dpip_pkg::DefMaxLen) begin
                if (r.ch == dpip_pkg::CharNul) begin
                    ended = 1'b1;
                end else begin
                    live++;
                end
            end
            send_byte(r);
        end
        live_items += live;
    endtask

    task send_text(string s);
        path_buf.delete();
        for (int i = 0; i < s.len(); i++) put(t_byte'(s[i]));
        send_path();
    endtask

    initial begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_req     <= '0;
        live_items = 0;
        burst_left = $urandom_range(1, 20);
        hold_req   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        path_buf.delete();
        put(dpip_pkg::CharNul);
        send_path();
        send_text(".");
        send_text("-5.%dz..x");
        send_text("--5.5-3.-.7");
        send_text("90..4294967297");
        path_buf.delete();
        put(8'hff);
        put(dpip_pkg::CharDot);
        put(dpip_pkg::CharZero + 8'd1);
        put(dpip_pkg::CharNul);
        put(dpip_pkg::CharZero + 8'd2);
        put(8'h80);
        send_path();

        hold_req   = 1'b1;
        live_items = 0;
        while (live_items < RandomItems) begin
            make_path();
            send_path();
        end
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // The receiver holds off once for a long stretch so that a final request backs up the input.
    initial begin
        out_ready <= 1'b0;
        hold_done = 1'b0;
        rx_left   = 0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                if (rx_left <= 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(10, 80);
                end
                rx_left--;
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
